### hdl/hkt_pkg.sv
// Shared types, sizes and codes for the hashed key table.
`timescale 1ns / 1ps
package hkt_pkg;

   localparam int BUCKETS   = 64;
   localparam int WAYS      = 4;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int ADDR_W    = BKT_W + WAY_W;
   localparam int SLOTS     = 1 << ADDR_W;
   localparam int KEY_W     = 14;
   localparam int NUM_W     = 16;
   localparam int ENTRY_W   = KEY_W + NUM_W;
   localparam int HASH_W    = 14;
   localparam int REM_W     = 8;
   localparam int DIV_STEPS = HASH_W / 2;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int BIDX_W    = 6;
   localparam int SIZE_W    = 7;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [NUM_W-1:0]   num_type;
   typedef logic [BKT_W-1:0]   bkt_type;
   typedef logic [HASH_W-1:0]  hash_type;
   typedef logic [REM_W-1:0]   rem_type;
   typedef logic [STEP_W-1:0]  step_type;
   typedef logic [BIDX_W-1:0]  bidx_type;
   typedef logic [2:0]         status_type;

   localparam status_type ST_INSERTED  = 3'd0;
   localparam status_type ST_DUPLICATE = 3'd1;
   localparam status_type ST_FOUND     = 3'd2;
   localparam status_type ST_NOT_FOUND = 3'd3;
   localparam status_type ST_FULL      = 3'd4;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   // one classified request on its way from front to back
   typedef struct packed {
      cmd_type cmd;
      key_type key;
      num_type num;
      bkt_type bucket;
   } item_type;

   // result handed from back to the output register
   typedef struct packed {
      logic       load;
      status_type status;
      bkt_type    bucket;
      num_type    found;
   } result_type;

endpackage

### hdl/hkt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/hkt_front.sv
// Front end: takes a request, hashes the key and reduces it modulo the table size.
`timescale 1ns / 1ps
module hkt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hkt_pkg::cmd_type  in_cmd,
   input  hkt_pkg::key_type  in_key,
   input  hkt_pkg::num_type  in_num,
   input  hkt_pkg::rem_type  eff_size,
   output logic              q_push,
   output hkt_pkg::item_type q_item,
   input  logic              q_full
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type   state_ff, state_in;
   hkt_pkg::cmd_type  cmd_ff, cmd_in;
   hkt_pkg::key_type  key_ff, key_in;
   hkt_pkg::num_type  num_ff, num_in;
   hkt_pkg::hash_type n_ff, n_in;
   hkt_pkg::rem_type  rem_ff, rem_in;
   hkt_pkg::step_type step_ff, step_in;

   // one restoring step: shift in a bit, subtract the modulus if it fits
   function automatic hkt_pkg::rem_type rem_step(input hkt_pkg::rem_type r,
                                                  input logic b,
                                                  input hkt_pkg::rem_type s);
      hkt_pkg::rem_type t;
      t = {r[hkt_pkg::REM_W-2:0], b};
      return (t >= s) ? t - s : t;
   endfunction

   always_comb begin
      hkt_pkg::rem_type r1;
      state_in = state_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      num_in   = num_ff;
      n_in     = n_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      r1       = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               cmd_in  = in_cmd;
               key_in  = in_key;
               num_in  = in_num;
               n_in    = hkt_pkg::hash_type'(in_key[13:9]) * hkt_pkg::hash_type'(260)
                       + hkt_pkg::hash_type'(in_key[8:4]) * hkt_pkg::hash_type'(10)
                       + hkt_pkg::hash_type'(in_key[3:0]);
               rem_in  = '0;
               step_in = '0;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            r1      = rem_step(rem_ff, n_ff[hkt_pkg::HASH_W-1], eff_size);
            rem_in  = rem_step(r1, n_ff[hkt_pkg::HASH_W-2], eff_size);
            n_in    = n_ff << 2;
            step_in = step_ff + 1'b1;
            if (step_ff == hkt_pkg::step_type'(hkt_pkg::DIV_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      num_ff  <= num_in;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign in_ready      = (state_ff == F_IDLE);
   assign q_push        = (state_ff == F_PUSH) && !q_full;
   assign q_item.cmd    = cmd_ff;
   assign q_item.key    = key_ff;
   assign q_item.num    = num_ff;
   assign q_item.bucket = hkt_pkg::bkt_type'(rem_ff);

endmodule

### hdl/hkt_queue.sv
// Short FIFO of classified requests between front and back.
`timescale 1ns / 1ps
module hkt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hkt_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output hkt_pkg::item_type head,
   output logic              empty
);

   hkt_pkg::item_type           slot_ff [hkt_pkg::Q_DEPTH];
   logic [hkt_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hkt_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hkt_pkg::Q_PTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == (hkt_pkg::Q_PTR_W+1)'(hkt_pkg::Q_DEPTH));

endmodule

### hdl/hkt_back.sv
// Back end: walks the ways of a bucket in RAM, decides, and inserts new entries.
`timescale 1ns / 1ps
module hkt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  hkt_pkg::item_type  q_head,
   output logic               q_pop,
   input  logic               out_free,
   output hkt_pkg::result_type result
);

   typedef enum logic [2:0] {
      B_IDLE   = 3'b001,
      B_WALK   = 3'b010,
      B_DECIDE = 3'b100
   } back_state_type;

   typedef logic [hkt_pkg::ADDR_W-1:0] addr_type;
   typedef logic [hkt_pkg::WAY_W-1:0]  way_type;
   typedef logic [hkt_pkg::WAY_W:0]    cnt_type;

   back_state_type    state_ff, state_in;
   hkt_pkg::item_type item_ff, item_in;
   cnt_type           rd_cnt_ff, rd_cnt_in;
   logic              pend_ff, pend_in;
   way_type           pend_way_ff, pend_way_in;
   logic              vld_rd_ff, vld_rd_in;
   logic              hit_ff, hit_in;
   hkt_pkg::num_type  hit_num_ff, hit_num_in;
   logic              free_ff, free_in;
   way_type           free_way_ff, free_way_in;
   logic [hkt_pkg::SLOTS-1:0] valid_ff;

   logic                          issue;
   addr_type                      rd_addr;
   logic [hkt_pkg::ENTRY_W-1:0]   rd_data;
   logic                          wr_en;
   addr_type                      wr_addr;
   logic [hkt_pkg::ENTRY_W-1:0]   wr_data;

   hkt_ram #(
      .WIDTH (hkt_pkg::ENTRY_W),
      .DEPTH (hkt_pkg::SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign issue   = (state_ff == B_WALK) && (rd_cnt_ff < cnt_type'(hkt_pkg::WAYS));
   assign rd_addr = {item_ff.bucket, rd_cnt_ff[hkt_pkg::WAY_W-1:0]};
   assign wr_addr = {item_ff.bucket, free_way_ff};
   assign wr_data = {item_ff.key, item_ff.num};

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      rd_cnt_in   = rd_cnt_ff;
      pend_in     = 1'b0;
      pend_way_in = pend_way_ff;
      vld_rd_in   = vld_rd_ff;
      hit_in      = hit_ff;
      hit_num_in  = hit_num_ff;
      free_in     = free_ff;
      free_way_in = free_way_ff;
      q_pop       = 1'b0;
      wr_en       = 1'b0;
      result.load   = 1'b0;
      result.bucket = item_ff.bucket;
      result.found  = '0;
      result.status = hkt_pkg::ST_NOT_FOUND;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               item_in   = q_head;
               rd_cnt_in = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               state_in  = B_WALK;
            end
         end
         B_WALK: begin
            if (issue) begin
               rd_cnt_in   = rd_cnt_ff + 1'b1;
               pend_in     = 1'b1;
               pend_way_in = rd_cnt_ff[hkt_pkg::WAY_W-1:0];
               vld_rd_in   = valid_ff[rd_addr];
            end
            // read data of the previous cycle's way is compared here
            if (pend_ff) begin
               if (vld_rd_ff) begin
                  if (!hit_ff && rd_data[hkt_pkg::ENTRY_W-1:hkt_pkg::NUM_W] == item_ff.key) begin
                     hit_in     = 1'b1;
                     hit_num_in = rd_data[hkt_pkg::NUM_W-1:0];
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_way_in = pend_way_ff;
               end
               if (pend_way_ff == way_type'(hkt_pkg::WAYS - 1)) begin
                  state_in = B_DECIDE;
               end
            end
         end
         B_DECIDE: begin
            if (item_ff.cmd == hkt_pkg::CMD_INSERT) begin
               if (hit_ff) begin
                  result.status = hkt_pkg::ST_DUPLICATE;
               end else if (!free_ff) begin
                  result.status = hkt_pkg::ST_FULL;
               end else begin
                  result.status = hkt_pkg::ST_INSERTED;
               end
            end else if (hit_ff) begin
               result.status = hkt_pkg::ST_FOUND;
               result.found  = hit_num_ff;
            end
            if (out_free) begin
               result.load = 1'b1;
               wr_en    = (item_ff.cmd == hkt_pkg::CMD_INSERT) && !hit_ff && free_ff;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         pend_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
      item_ff     <= item_in;
      rd_cnt_ff   <= rd_cnt_in;
      pend_way_ff <= pend_way_in;
      vld_rd_ff   <= vld_rd_in;
      hit_ff      <= hit_in;
      hit_num_ff  <= hit_num_in;
      free_ff     <= free_in;
      free_way_ff <= free_way_in;
   end

endmodule

### hdl/hashed_key_table.sv
// Top level of the hashed key table: ports, size register and output register.
`timescale 1ns / 1ps
// Hash table of three-character keys with a 16-bit number each, BUCKETS
// buckets of WAYS entries. A request (tuser 0 insert, 1 search) is hashed and
// reduced modulo the table size by a two-bit-per-cycle remainder unit in the
// front end, then queued; the back end reads the bucket's ways from one RAM
// read port, one way per cycle, then decides and writes. Front and back overlap
// through the queue, so the front end can take a new request while the back end
// still works on the last one. Entry valid bits live in flops cleared by reset,
// so the table is usable right after reset.
module hashed_key_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // key_first_letter, key_second_letter, key_digit, entry_number
   input  logic        req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // bucket_index, found_number
   output logic [2:0]  rsp_tuser,  // status
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);

   logic [hkt_pkg::SIZE_W-1:0] table_size_ff;
   hkt_pkg::rem_type           eff_size;
   logic                       q_push, q_full, q_pop, q_empty;
   hkt_pkg::item_type          q_in_item, q_head;
   hkt_pkg::result_type        result;
   logic                       out_free;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0]                rsp_tdata_ff;
   hkt_pkg::status_type        rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= hkt_pkg::SIZE_W'(64);
      end else if (csr_we) begin
         table_size_ff <= csr_wdata;
      end
   end

   // zero acts as one, anything above the bucket count saturates
   always_comb begin
      if (table_size_ff == '0) begin
         eff_size = hkt_pkg::rem_type'(1);
      end else if (32'(table_size_ff) > hkt_pkg::BUCKETS) begin
         eff_size = hkt_pkg::rem_type'(hkt_pkg::BUCKETS);
      end else begin
         eff_size = hkt_pkg::rem_type'(table_size_ff);
      end
   end

   hkt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_cmd   (hkt_pkg::cmd_type'(req_tuser)),
      .in_key   (hkt_pkg::key_type'({req_tdata[4:0], req_tdata[9:5], req_tdata[13:10]})),
      .in_num   (req_tdata[29:14]),
      .eff_size (eff_size),
      .q_push   (q_push),
      .q_item   (q_in_item),
      .q_full   (q_full)
   );

   hkt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   hkt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .out_free (out_free),
      .result   (result)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (result.load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (result.load) begin
         rsp_tdata_ff  <= {2'b00, result.found, hkt_pkg::bidx_type'(result.bucket)};
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("queue push while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("queue pop while empty");

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != hkt_pkg::ST_FOUND) |-> (rsp_tdata[21:6] == 16'd0))
      else $error("nonzero number without a hit");

   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({2'b00, rsp_tdata[5:0]} < eff_size))
      else $error("bucket outside table size");

endmodule

### verif/tb_hashed_key_table.sv
// Self-checking testbench for the hashed key table: directed and random requests.
`timescale 1ns / 1ps
module tb_hashed_key_table;
   import hkt_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int LETTER_WEIGHT = 260;
   localparam int DIGIT_WEIGHT  = 10;
   localparam int ITEMS_PER_PHASE = 120;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HISTORY_DEPTH   = 48;

   typedef struct {
      status_type status;
      bidx_type   bucket;
      num_type    found;
   } table_answer;

   // shadow copy of the bucket store plus the queue of answers still owed
   class key_table_checker;
      logic [SIZE_W-1:0] size_reg;
      bit                slot_valid [BUCKETS*WAYS];
      key_type           slot_key   [BUCKETS*WAYS];
      num_type           slot_num   [BUCKETS*WAYS];
      table_answer       pending_answers [$];
      int                mismatches;
      int                requests;
      int                status_seen [5];

      function new();
         size_reg = SIZE_W'(BUCKETS);
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         foreach (status_seen[i]) status_seen[i] = 0;
         mismatches = 0;
         requests   = 0;
      endfunction

      function void set_size(logic [SIZE_W-1:0] value);
         size_reg = value;
      endfunction

      // apply one accepted request to the shadow table and queue its answer
      function void note_request(cmd_type cmd, key_type key, num_type num);
         int unsigned modulus;
         int unsigned hash_val;
         int unsigned bkt;
         int unsigned base;
         int          hit_way;
         int          free_way;
         table_answer ans;
         if (size_reg == 0)
            modulus = 1;
         else if (size_reg > BUCKETS)
            modulus = BUCKETS;
         else
            modulus = size_reg;
         hash_val = LETTER_WEIGHT * key[13:9] + DIGIT_WEIGHT * key[8:4] + key[3:0];
         bkt      = hash_val % modulus;
         base     = bkt * WAYS;
         hit_way  = -1;
         free_way = -1;
         for (int w = 0; w < WAYS; w++) begin
            if (slot_valid[base + w]) begin
               if (hit_way < 0 && slot_key[base + w] == key) hit_way = w;
            end else if (free_way < 0) begin
               free_way = w;
            end
         end
         ans.bucket = bidx_type'(bkt);
         ans.found  = '0;
         if (cmd == CMD_INSERT) begin
            if (hit_way >= 0) begin
               ans.status = ST_DUPLICATE;
            end else if (free_way < 0) begin
               ans.status = ST_FULL;
            end else begin
               slot_valid[base + free_way] = 1'b1;
               slot_key[base + free_way]   = key;
               slot_num[base + free_way]   = num;
               ans.status = ST_INSERTED;
            end
         end else begin
            if (hit_way >= 0) begin
               ans.status = ST_FOUND;
               ans.found  = slot_num[base + hit_way];
            end else begin
               ans.status = ST_NOT_FOUND;
            end
         end
         requests++;
         pending_answers = {pending_answers, ans};
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         mismatches++;
         if (mismatches <= 40)
            $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      endtask

      task check_result(status_type status, bidx_type bucket, num_type found);
         table_answer want;
         if (pending_answers.size() == 0) begin
            report("response with nothing outstanding", status, 0);
            return;
         end
         want = pending_answers.pop_front();
         if (status != want.status) report("status", status, want.status);
         if (bucket != want.bucket) report("bucket_index", bucket, want.bucket);
         if (found != want.found) report("found_number", found, want.found);
         if (want.status <= ST_FULL) status_seen[want.status]++;
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;
   logic [2:0]        rsp_tuser;
   logic              csr_we = 1'b0;
   logic [6:0]        csr_wdata = '0;

   key_table_checker  sb;
   key_type           recent_keys [$];
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                hold_request = 0;
   int                hold_left = 0;
   int                idle_cycles = 0;
   int                sizes_used = 1;

   hashed_key_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // receiver: long hold-off when asked, otherwise random stalls
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(cmd_type'(req_tuser),
                            {req_tdata[4:0], req_tdata[9:5], req_tdata[13:10]},
                            req_tdata[29:14]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata[5:0], rsp_tdata[21:6]);
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   task send_request(cmd_type cmd, logic [4:0] l1, logic [4:0] l2, logic [3:0] dg,
                     num_type num);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, num, dg, l2, l1};
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and let every outstanding response come back
   task finish_burst();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_answers.size() != 0) @(posedge clock);
   endtask

   task write_table_size(logic [6:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.set_size(value);
      sizes_used++;
   endtask

   task set_idle_mode(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 71; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 71; end
         default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
   endtask

   // mostly well-formed insert/search traffic on recently used keys, some noise
   task random_request();
      int          pick;
      logic [4:0]  l1;
      logic [4:0]  l2;
      logic [3:0]  dg;
      cmd_type     cmd;
      pick = $urandom_range(99);
      l1   = 5'($urandom_range(25));
      l2   = 5'($urandom_range(25));
      dg   = 4'($urandom_range(9));
      cmd  = CMD_INSERT;
      if (pick < 40) begin
         cmd = CMD_INSERT;
      end else if (pick < 70 && recent_keys.size() > 0) begin
         {l1, l2, dg} = recent_keys[$urandom_range(recent_keys.size() - 1)];
         cmd = CMD_SEARCH;
      end else if (pick < 80 && recent_keys.size() > 0) begin
         {l1, l2, dg} = recent_keys[$urandom_range(recent_keys.size() - 1)];
         cmd = CMD_INSERT;
      end else if (pick < 90) begin
         cmd = CMD_SEARCH;
      end else begin
         // raw field values, also outside the key alphabet
         l1  = 5'($urandom_range(31));
         l2  = 5'($urandom_range(31));
         dg  = 4'($urandom_range(15));
         cmd = cmd_type'($urandom_range(1));
      end
      if (cmd == CMD_INSERT) begin
         recent_keys = {recent_keys, key_type'({l1, l2, dg})};
         if (recent_keys.size() > HISTORY_DEPTH) void'(recent_keys.pop_front());
      end
      send_request(cmd, l1, l2, dg, num_type'($urandom));
   endtask

   initial begin : stimulus
      int phase_sizes [9];
      sb = new();
      phase_sizes = '{1, 0, 127, 65, 13, 64, 37, 2, 50};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty search, duplicate, extremes of key and number
      set_idle_mode(0);
      send_request(CMD_SEARCH, 5'd0, 5'd0, 4'd0, 16'h1234);
      send_request(CMD_INSERT, 5'd0, 5'd0, 4'd0, 16'h0000);
      send_request(CMD_INSERT, 5'd0, 5'd0, 4'd0, 16'h5A5A);
      send_request(CMD_SEARCH, 5'd0, 5'd0, 4'd0, 16'hFFFF);
      send_request(CMD_INSERT, 5'd25, 5'd25, 4'd9, 16'hFFFF);
      send_request(CMD_SEARCH, 5'd25, 5'd25, 4'd9, 16'h0000);
      send_request(CMD_INSERT, 5'd31, 5'd31, 4'd15, 16'hA5A5);
      send_request(CMD_SEARCH, 5'd31, 5'd31, 4'd15, 16'h0000);
      send_request(CMD_INSERT, 5'd25, 5'd0, 4'd15, 16'h5A5A);
      send_request(CMD_SEARCH, 5'd25, 5'd0, 4'd15, 16'h0000);
      // five keys landing in bucket 1, which already holds one: the fourth and fifth find it full
      send_request(CMD_INSERT, 5'd0, 5'd0, 4'd1, 16'h0001);
      send_request(CMD_INSERT, 5'd0, 5'd6, 4'd5, 16'h0002);
      send_request(CMD_INSERT, 5'd0, 5'd12, 4'd9, 16'h0004);
      send_request(CMD_INSERT, 5'd0, 5'd19, 4'd3, 16'h0008);
      send_request(CMD_INSERT, 5'd0, 5'd25, 4'd7, 16'h0010);
      send_request(CMD_SEARCH, 5'd0, 5'd25, 4'd7, 16'h0000);
      send_request(CMD_SEARCH, 5'd0, 5'd12, 4'd9, 16'h0000);
      send_request(CMD_INSERT, 5'd0, 5'd6, 4'd5, 16'h7777);
      finish_burst();

      // random phases, each under its own table size and idle pattern
      for (int p = 0; p < 9; p++) begin
         write_table_size(7'(phase_sizes[p]));
         set_idle_mode(p % 4);
         if (p == 4) hold_request = HOLD_OFF_CYCLES;
         repeat (ITEMS_PER_PHASE) random_request();
         finish_burst();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d requests over %0d table sizes, including 0, 1, 64 and above 64",
               sb.requests, sizes_used);
      $display("answers: %0d inserted, %0d duplicate, %0d found, %0d not found, %0d full",
               sb.status_seen[ST_INSERTED], sb.status_seen[ST_DUPLICATE],
               sb.status_seen[ST_FOUND], sb.status_seen[ST_NOT_FOUND],
               sb.status_seen[ST_FULL]);
      if (sb.mismatches == 0 && sb.pending_answers.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
